/* rtl/core/sspe_pkg.sv */
package sspe_pkg;

    // default fraction bits of coordinates and distances
    localparam int COORD_FRAC_BITS = 16;

    // fixed field widths
    localparam int COORD_W  = 17;
    localparam int ENERGY_W = 48;
    localparam int TALLY_W  = 16;

    // shell range after reset, about 0.05 in Q1.16
    localparam logic [COORD_W-1:0] SHELL_RANGE_RESET = COORD_W'(3277);

    // nine lattice translates, i and j each in -1..1
    localparam int LANES = 9;
    localparam int TAPS  = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQUARE,
        ST_MIN,
        ST_ROOT,
        ST_CHECK,
        ST_GAP,
        ST_ACCUM,
        ST_FINISH
    } state_t;

    // integer square root, evaluated at elaboration
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = v;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // sqrt(3)/2 with f fraction bits, rounded
    function automatic logic [63:0] box_hy(input int f);
        return (isqrt64(64'd3 << (2 * f)) + 64'd1) >> 1;
    endfunction

endpackage

/* rtl/core/soft_shell_pair_energy.sv */
// Soft-shell pair energy of one particle against a stream of its same-species partners in a
// periodic unit rhombic box of the triangular lattice. Each s_ transaction carries the particle
// (center), one partner and two flags; a partner marked is_self adds nothing. For every other
// partner the nine translates of the partner are squared in parallel by bit-serial squarers,
// the smallest squared distance is found by a scan over the nine lanes, its square root is
// formed one bit per cycle, and when the distance lies below shell_range the squared gap is
// formed bit-serially and added to a saturating 48-bit Q16.32 energy; the overlap count
// saturates at 65535. The transaction marked last_partner produces one m_ transaction with the
// energy and count, and the sums clear. One partner is in flight at a time, from acceptance
// to the next s_ready; an is_self partner skips every step, a non-overlapping one skips the gap
// square and the accumulation. A result waits in an output register, so the next partner is
// taken while it is pending; only a further last partner waits for that register to drain.
// shell_range is written through cfg_wr_en / cfg_wr_data; the user must write it only while
// the block is idle, which the block itself does not enforce.
module soft_shell_pair_energy #(
    parameter int COORD_FRAC_BITS = sspe_pkg::COORD_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // shell range register
    input  logic                          cfg_wr_en,
    input  logic [sspe_pkg::COORD_W-1:0]  cfg_wr_data,

    // partner transactions
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sspe_pkg::COORD_W-1:0]  s_center_x,
    input  logic [sspe_pkg::COORD_W-1:0]  s_center_y,
    input  logic [sspe_pkg::COORD_W-1:0]  s_partner_x,
    input  logic [sspe_pkg::COORD_W-1:0]  s_partner_y,
    input  logic                          s_is_self,
    input  logic                          s_last_partner,

    // result transactions
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sspe_pkg::ENERGY_W-1:0] m_energy,
    output logic [sspe_pkg::TALLY_W-1:0]  m_overlap_count
);

    localparam int COORD_W  = sspe_pkg::COORD_W;
    localparam int ENERGY_W = sspe_pkg::ENERGY_W;
    localparam int TALLY_W  = sspe_pkg::TALLY_W;
    localparam int LANES    = sspe_pkg::LANES;
    localparam int TAPS     = sspe_pkg::TAPS;

    // box length 1.0, half of it, and sqrt(3)/2, all with COORD_FRAC_BITS fraction bits
    localparam int BOX_LEN  = 1 << COORD_FRAC_BITS;
    localparam int BOX_HALF = 1 << (COORD_FRAC_BITS - 1);
    localparam int BOX_HY   = int'(sspe_pkg::box_hy(COORD_FRAC_BITS));

    // magnitude of a translated difference, covers |d| + 1.5 box lengths
    localparam int MAG_W   = ((COORD_W > COORD_FRAC_BITS + 1) ? COORD_W : COORD_FRAC_BITS + 1) + 1;
    localparam int T_W     = MAG_W + 1;          // signed translated difference
    localparam int R2_W    = 2 * MAG_W + 1;      // sum of two squares
    localparam int DIST_W  = (R2_W + 1) / 2;     // root of a squared distance
    localparam int RAD_W   = 2 * DIST_W;         // radicand, padded to whole bit pairs
    localparam int REM_W   = DIST_W + 1;         // partial remainder of the root
    localparam int GAP_W   = COORD_W;
    localparam int GSQ_W   = 2 * GAP_W;
    localparam int SUM_W   = ENERGY_W + 1;

    localparam int CNT_A   = (MAG_W > DIST_W) ? MAG_W : DIST_W;
    localparam int CNT_B   = (GAP_W > LANES) ? GAP_W : LANES;
    localparam int CNT_MAX = (CNT_A > CNT_B) ? CNT_A : CNT_B;
    localparam int CNT_W   = $clog2(CNT_MAX);

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam logic [TALLY_W-1:0]  TALLY_MAX  = '1;
    localparam logic [SUM_W-1:0]    SUM_LIMIT  = SUM_W'(ENERGY_MAX);

    // control
    sspe_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             out_load;
    logic             out_free;
    logic             hit;

    // configuration and running sums
    logic [COORD_W-1:0]  shell_range_reg, shell_range_next;
    logic [ENERGY_W-1:0] energy_sum_reg, energy_sum_next;
    logic [TALLY_W-1:0]  tally_reg, tally_next;

    // accepted differences
    logic signed [T_W-1:0] dx_reg, dx_next;
    logic signed [T_W-1:0] dy_reg, dy_next;

    // serial squarer lanes: x magnitude per lane, y magnitude per row j
    logic [MAG_W-1:0] txv_reg [LANES];
    logic [MAG_W-1:0] txv_next [LANES];
    logic [MAG_W-1:0] txs_reg [LANES];
    logic [MAG_W-1:0] txs_next [LANES];
    logic [MAG_W-1:0] tyv_reg [TAPS];
    logic [MAG_W-1:0] tyv_next [TAPS];
    logic [MAG_W-1:0] tys_reg [TAPS];
    logic [MAG_W-1:0] tys_next [TAPS];
    logic [R2_W-1:0]  acc_reg [LANES];
    logic [R2_W-1:0]  acc_next [LANES];

    // minimum scan
    logic [R2_W-1:0] best_reg, best_next;

    // bit-serial root
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIST_W-1:0] root_reg, root_next;

    // serial gap square
    logic [GAP_W-1:0] gval_reg, gval_next;
    logic [GAP_W-1:0] gsh_reg, gsh_next;
    logic [GSQ_W-1:0] eacc_reg, eacc_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [ENERGY_W-1:0] m_energy_reg, m_energy_next;
    logic [TALLY_W-1:0]  m_count_reg, m_count_next;

    assign out_free = !m_valid_reg || m_ready;
    assign hit      = root_reg < DIST_W'(shell_range_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sspe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_is_self ? sspe_pkg::ST_FINISH : sspe_pkg::ST_LOAD;
                end
            end
            sspe_pkg::ST_LOAD: begin
                state_next = sspe_pkg::ST_SQUARE;
            end
            sspe_pkg::ST_SQUARE: begin
                if (cnt_reg == '0) begin
                    state_next = sspe_pkg::ST_MIN;
                end
            end
            sspe_pkg::ST_MIN: begin
                if (cnt_reg == '0) begin
                    state_next = sspe_pkg::ST_ROOT;
                end
            end
            sspe_pkg::ST_ROOT: begin
                if (cnt_reg == '0) begin
                    state_next = sspe_pkg::ST_CHECK;
                end
            end
            sspe_pkg::ST_CHECK: begin
                state_next = hit ? sspe_pkg::ST_GAP : sspe_pkg::ST_FINISH;
            end
            sspe_pkg::ST_GAP: begin
                if (cnt_reg == '0) begin
                    state_next = sspe_pkg::ST_ACCUM;
                end
            end
            sspe_pkg::ST_ACCUM: begin
                state_next = sspe_pkg::ST_FINISH;
            end
            sspe_pkg::ST_FINISH: begin
                if (!last_reg || out_free) begin
                    state_next = sspe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sspe_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            sspe_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            sspe_pkg::ST_FINISH: begin
                out_load = last_reg && out_free;
            end
            default: begin
                s_ready  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        logic signed [T_W-1:0]  tx_c;
        logic signed [T_W-1:0]  ty_c;
        logic [REM_W+1:0]       rem_t;
        logic [REM_W+1:0]       trial;
        logic [SUM_W-1:0]       sum_ext;

        cnt_next         = cnt_reg;
        last_next        = last_reg;
        shell_range_next = shell_range_reg;
        energy_sum_next  = energy_sum_reg;
        tally_next       = tally_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        txv_next         = txv_reg;
        txs_next         = txs_reg;
        tyv_next         = tyv_reg;
        tys_next         = tys_reg;
        acc_next         = acc_reg;
        best_next        = best_reg;
        rad_next         = rad_reg;
        rem_next         = rem_reg;
        root_next        = root_reg;
        gval_next        = gval_reg;
        gsh_next         = gsh_reg;
        eacc_next        = eacc_reg;
        tx_c             = '0;
        ty_c             = '0;
        rem_t            = '0;
        trial            = '0;
        sum_ext          = '0;

        if (cfg_wr_en) begin
            shell_range_next = cfg_wr_data;
        end

        case (state_reg)
            sspe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    dx_next   = T_W'($signed({1'b0, s_center_x}))
                              - T_W'($signed({1'b0, s_partner_x}));
                    dy_next   = T_W'($signed({1'b0, s_center_y}))
                              - T_W'($signed({1'b0, s_partner_y}));
                    last_next = s_last_partner;
                end
            end
            sspe_pkg::ST_LOAD: begin
                // translate by i*a1 + j*a2 and take magnitudes
                for (int ix = 0; ix < TAPS; ix++) begin
                    for (int jy = 0; jy < TAPS; jy++) begin
                        tx_c = dx_reg + T_W'((ix - 1) * BOX_LEN + (jy - 1) * BOX_HALF);
                        txv_next[ix * TAPS + jy] = tx_c[T_W-1] ? MAG_W'(-tx_c) : MAG_W'(tx_c);
                        txs_next[ix * TAPS + jy] = tx_c[T_W-1] ? MAG_W'(-tx_c) : MAG_W'(tx_c);
                        acc_next[ix * TAPS + jy] = '0;
                    end
                end
                for (int jy = 0; jy < TAPS; jy++) begin
                    ty_c = dy_reg + T_W'((jy - 1) * BOX_HY);
                    tyv_next[jy] = ty_c[T_W-1] ? MAG_W'(-ty_c) : MAG_W'(ty_c);
                    tys_next[jy] = ty_c[T_W-1] ? MAG_W'(-ty_c) : MAG_W'(ty_c);
                end
                cnt_next = CNT_W'(MAG_W - 1);
            end
            sspe_pkg::ST_SQUARE: begin
                // msb-first shift-add: acc = tx^2 + ty^2 once every one of the MAG_W multiplier bits is used
                for (int k = 0; k < LANES; k++) begin
                    acc_next[k] = {acc_reg[k][R2_W-2:0], 1'b0}
                                + (txs_reg[k][MAG_W-1] ? R2_W'(txv_reg[k]) : R2_W'(0))
                                + (tys_reg[k % TAPS][MAG_W-1] ? R2_W'(tyv_reg[k % TAPS])
                                                              : R2_W'(0));
                    txs_next[k] = {txs_reg[k][MAG_W-2:0], 1'b0};
                end
                for (int jy = 0; jy < TAPS; jy++) begin
                    tys_next[jy] = {tys_reg[jy][MAG_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    cnt_next = CNT_W'(LANES - 1);
                end
            end
            sspe_pkg::ST_MIN: begin
                // lanes shift toward lane 0, one compare per cycle
                if (cnt_reg == CNT_W'(LANES - 1) || acc_reg[0] < best_reg) begin
                    best_next = acc_reg[0];
                end
                for (int k = 0; k < LANES - 1; k++) begin
                    acc_next[k] = acc_reg[k + 1];
                end
                acc_next[LANES-1] = '0;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    rad_next  = RAD_W'(best_next);
                    rem_next  = '0;
                    root_next = '0;
                    cnt_next  = CNT_W'(DIST_W - 1);
                end
            end
            sspe_pkg::ST_ROOT: begin
                // one root bit per cycle from the top bit pair of the radicand
                rem_t    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
                trial    = (REM_W + 2)'({root_reg, 2'b01});
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                if (rem_t >= trial) begin
                    rem_next  = REM_W'(rem_t - trial);
                    root_next = {root_reg[DIST_W-2:0], 1'b1};
                end else begin
                    rem_next  = REM_W'(rem_t);
                    root_next = {root_reg[DIST_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            sspe_pkg::ST_CHECK: begin
                gval_next = shell_range_reg - root_reg[GAP_W-1:0];
                gsh_next  = shell_range_reg - root_reg[GAP_W-1:0];
                eacc_next = '0;
                cnt_next  = CNT_W'(GAP_W - 1);
            end
            sspe_pkg::ST_GAP: begin
                eacc_next = {eacc_reg[GSQ_W-2:0], 1'b0}
                          + (gsh_reg[GAP_W-1] ? GSQ_W'(gval_reg) : GSQ_W'(0));
                gsh_next  = {gsh_reg[GAP_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
            end
            sspe_pkg::ST_ACCUM: begin
                // saturating energy and overlap count
                sum_ext = {1'b0, energy_sum_reg} + SUM_W'(eacc_reg);
                if (sum_ext >= SUM_LIMIT) begin
                    energy_sum_next = ENERGY_MAX;
                end else begin
                    energy_sum_next = sum_ext[ENERGY_W-1:0];
                end
                if (tally_reg != TALLY_MAX) begin
                    tally_next = tally_reg + 1'b1;
                end
            end
            sspe_pkg::ST_FINISH: begin
                if (out_load) begin
                    energy_sum_next = '0;
                    tally_next      = '0;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_energy_next = m_energy_reg;
        m_count_next  = m_count_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_energy_next = energy_sum_reg;
            m_count_next  = tally_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_energy        = m_energy_reg;
    assign m_overlap_count = m_count_reg;

    // control state and sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= sspe_pkg::ST_IDLE;
            cnt_reg         <= '0;
            last_reg        <= 1'b0;
            shell_range_reg <= sspe_pkg::SHELL_RANGE_RESET;
            energy_sum_reg  <= '0;
            tally_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            last_reg        <= last_next;
            shell_range_reg <= shell_range_next;
            energy_sum_reg  <= energy_sum_next;
            tally_reg       <= tally_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        txv_reg      <= txv_next;
        txs_reg      <= txs_next;
        tyv_reg      <= tyv_next;
        tys_reg      <= tys_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        gval_reg     <= gval_next;
        gsh_reg      <= gsh_next;
        eacc_reg     <= eacc_next;
        m_energy_reg <= m_energy_next;
        m_count_reg  <= m_count_next;
    end

endmodule
